### sv/frwl_pkg.sv
// ----------------------------------------------------------------------------
// frwl_pkg
// Shared types and constants for the fair reader/writer lock manager.
// ----------------------------------------------------------------------------
package frwl_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;

    localparam int REQ_W     = 8;
    localparam int ID_W      = (ID_BITS < REQ_W) ? ID_BITS : REQ_W;
    localparam int QA_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W     = 8;

    localparam logic [REQ_W-1:0] ID_MASK    = REQ_W'((1 << ID_W) - 1);
    localparam logic [CNT_W-1:0] READER_MAX = {CNT_W{1'b1}};

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;
    localparam logic KIND_WRITER = 1'b0;
    localparam logic KIND_READER = 1'b1;

    typedef enum logic [1:0] {
        OP_ACQ_WR,
        OP_ACQ_RD,
        OP_REL_WR,
        OP_REL_RD
    } t_op;

    typedef enum logic [2:0] {
        EV_GRANT     = 3'd0,
        EV_QUEUED    = 3'd1,
        EV_RELEASED  = 3'd2,
        EV_REJECT    = 3'd3,
        EV_BADUNLOCK = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_WAIT
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [REQ_W-1:0] id;
    } t_req;

    typedef struct packed {
        t_event           ev;
        logic [REQ_W-1:0] who;
        logic             kind;
        logic [CNT_W-1:0] rcnt;
        logic             wheld;
    } t_result;

endpackage

### sv/fifo_fair_reader_writer_lock.sv
// ----------------------------------------------------------------------------
// fifo_fair_reader_writer_lock
// FIFO-fair reader/writer lock manager: front intake plus lock engine.
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------
//   in      | i_in_valid / o_in_ready | i_cmd, i_kind, i_requester
//   out     | o_out_valid/ i_out_ready| o_event_res, o_who, o_who_kind,
//           |                         | o_readers_holding, o_writer_holding,
//           |                         | o_last
//
// Each request passes the engine's execute step, then its decide step; each
// cascaded grant adds a wait step (registered queue read) and a decide step.
// The intake buffers two requests, so input is taken while results stall.
// Synchronous active-low reset clears all control state; no clearing pass.
// A stalled output holds the engine in its decide step.
// ----------------------------------------------------------------------------
module fifo_fair_reader_writer_lock (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_cmd,
    input  logic       i_kind,
    input  logic [7:0] i_requester,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_event_res,
    output logic [7:0] o_who,
    output logic       o_who_kind,
    output logic [7:0] o_readers_holding,
    output logic       o_writer_holding,
    output logic       o_last
);
    import frwl_pkg::*;

    t_req req;
    logic req_valid, req_pop;

    frwl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_kind      (i_kind),
        .i_requester (i_requester),
        .o_req_valid (req_valid),
        .i_req_pop   (req_pop),
        .o_req       (req)
    );

    frwl_engine u_engine (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (req_valid),
        .o_req_pop         (req_pop),
        .i_req             (req),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_event_res       (o_event_res),
        .o_who             (o_who),
        .o_who_kind        (o_who_kind),
        .o_readers_holding (o_readers_holding),
        .o_writer_holding  (o_writer_holding),
        .o_last            (o_last)
    );

endmodule

### sv/frwl_front.sv
// ----------------------------------------------------------------------------
// frwl_front
// Request intake: decodes each request and buffers it in a two-entry queue.
// ----------------------------------------------------------------------------
module frwl_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_cmd,
    input  logic                 i_kind,
    input  logic [7:0]           i_requester,
    output logic                 o_req_valid,
    input  logic                 i_req_pop,
    output frwl_pkg::t_req       o_req
);
    import frwl_pkg::*;

    t_req       r_q [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_req       dec;
    logic       push, pop;

    always_comb begin
        unique case ({i_cmd, i_kind})
            {CMD_ACQUIRE, KIND_WRITER}: dec.op = OP_ACQ_WR;
            {CMD_ACQUIRE, KIND_READER}: dec.op = OP_ACQ_RD;
            {CMD_RELEASE, KIND_WRITER}: dec.op = OP_REL_WR;
            default:                    dec.op = OP_REL_RD;
        endcase
        dec.id = i_requester & ID_MASK;
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = i_req_pop && o_req_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= dec;
        end
    end

endmodule

### sv/frwl_engine.sv
// ----------------------------------------------------------------------------
// frwl_engine
// Lock state, wait queue and grant cascade; one result register at the output.
// ----------------------------------------------------------------------------
module frwl_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_pop,
    input  frwl_pkg::t_req       i_req,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_event_res,
    output logic [7:0]           o_who,
    output logic                 o_who_kind,
    output logic [7:0]           o_readers_holding,
    output logic                 o_writer_holding,
    output logic                 o_last
);
    import frwl_pkg::*;

    t_state               r_state, n_state;
    logic [QA_BITS-1:0]   r_head, n_head, r_tail, n_tail;
    logic [FILL_BITS-1:0] r_fill, n_fill;
    logic [CNT_W-1:0]     r_rcnt, n_rcnt;
    logic                 r_wheld, n_wheld;
    logic                 r_casc, n_casc;
    t_result              r_pend, n_pend;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out, n_out;
    logic                 r_last, n_last;

    logic [REQ_W:0]       r_mem [QUEUE_DEPTH];
    logic [REQ_W:0]       r_rd;
    logic                 mem_we;

    logic                 slot_free, conflict, is_reader, compat, more, take;

    assign slot_free = !r_out_valid || i_out_ready;
    assign is_reader = (i_req.op == OP_ACQ_RD) || (i_req.op == OP_REL_RD);
    assign conflict  = r_wheld || ((i_req.op == OP_ACQ_WR) && (r_rcnt != '0));
    assign compat    = !r_wheld && (r_rd[REQ_W] ? (r_rcnt != READER_MAX)
                                                : (r_rcnt == '0));
    assign more      = r_casc && (r_fill != '0) && compat;
    assign take      = (r_state == ST_IDLE) && i_req_valid;
    assign o_req_pop = take;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (slot_free) begin
                    n_state = more ? ST_WAIT : ST_IDLE;
                end
            end
            ST_WAIT: n_state = ST_DECIDE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_rcnt      = r_rcnt;
        n_wheld     = r_wheld;
        n_casc      = r_casc;
        n_pend      = r_pend;
        n_out       = r_out;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_out_ready;
        mem_we      = 1'b0;

        if (take) begin
            n_casc = 1'b0;
            unique case (i_req.op)
                OP_ACQ_WR, OP_ACQ_RD: begin
                    if ((r_fill == '0) && !conflict) begin
                        if (is_reader) begin
                            if (r_rcnt == READER_MAX) begin
                                n_pend.ev = EV_REJECT;
                            end else begin
                                n_rcnt    = r_rcnt + 1'b1;
                                n_pend.ev = EV_GRANT;
                            end
                        end else begin
                            n_wheld   = 1'b1;
                            n_pend.ev = EV_GRANT;
                        end
                    end else if (r_fill == FILL_BITS'(QUEUE_DEPTH)) begin
                        n_pend.ev = EV_REJECT;
                    end else begin
                        mem_we    = 1'b1;
                        n_tail    = (r_tail == QA_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                          : r_tail + 1'b1;
                        n_fill    = r_fill + 1'b1;
                        n_pend.ev = EV_QUEUED;
                    end
                end
                OP_REL_RD: begin
                    if (r_rcnt == '0) begin
                        n_pend.ev = EV_BADUNLOCK;
                    end else begin
                        n_rcnt    = r_rcnt - 1'b1;
                        n_pend.ev = EV_RELEASED;
                        n_casc    = 1'b1;
                    end
                end
                OP_REL_WR: begin
                    if (!r_wheld) begin
                        n_pend.ev = EV_BADUNLOCK;
                    end else begin
                        n_wheld   = 1'b0;
                        n_pend.ev = EV_RELEASED;
                        n_casc    = 1'b1;
                    end
                end
                default: n_pend.ev = EV_BADUNLOCK;
            endcase
            n_pend.who   = i_req.id;
            n_pend.kind  = is_reader;
            n_pend.rcnt  = n_rcnt;
            n_pend.wheld = n_wheld;
        end

        if ((r_state == ST_DECIDE) && slot_free) begin
            n_out       = r_pend;
            n_last      = !more;
            n_out_valid = 1'b1;
            if (more) begin
                n_head = (r_head == QA_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                n_fill = r_fill - 1'b1;
                if (r_rd[REQ_W]) begin
                    n_rcnt = r_rcnt + 1'b1;
                end else begin
                    n_wheld = 1'b1;
                end
                n_pend.ev    = EV_GRANT;
                n_pend.who   = r_rd[REQ_W-1:0];
                n_pend.kind  = r_rd[REQ_W];
                n_pend.rcnt  = n_rcnt;
                n_pend.wheld = n_wheld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_rcnt      <= '0;
            r_wheld     <= 1'b0;
            r_casc      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_rcnt      <= n_rcnt;
            r_wheld     <= n_wheld;
            r_casc      <= n_casc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
        r_last <= n_last;
    end

    // wait queue: written at tail, head read registered
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tail] <= {is_reader, i_req.id};
        end
        r_rd <= r_mem[r_head];
    end

    assign o_out_valid       = r_out_valid;
    assign o_event_res       = r_out.ev;
    assign o_who             = r_out.who;
    assign o_who_kind        = r_out.kind;
    assign o_readers_holding = r_out.rcnt;
    assign o_writer_holding  = r_out.wheld;
    assign o_last            = r_last;

endmodule
